[rtl/c2p_pkg.sv]
// Shared types and constants for the cartesian-to-polar CORDIC core.
// Datapath widths, the arctangent table and the stage payload struct.
// No dependencies.
`default_nettype none

package c2p_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int ITERATIONS  = 16;
    localparam int GUARD_BITS  = 16;

    localparam int OUT_WIDTH   = 16;

    // sign, room for negating the most negative input, CORDIC gain growth
    localparam int DW = COORD_WIDTH + GUARD_BITS + 3;
    localparam int ZW = 32;

    // magnitude is split into a 32-bit low word and a short high word
    localparam int RW = (DW - 1 > 33) ? DW - 1 : 33;
    localparam int HW = RW - 32;
    localparam int TW = HW + 33;

    localparam logic [31:0] GAIN_Q32  = 32'h9B74EDA8;
    localparam logic [ZW-1:0] HALF_TURN = 32'h80000000;

    // atan(2^-i), 2^32 per full turn
    localparam logic [ZW-1:0] ATAN_TABLE [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic [ZW-1:0]        z;
        logic                 zero;
    } t_vec;

endpackage

`default_nettype wire

[rtl/cartesian_to_polar_core.sv]
// Cartesian to polar conversion core: prep stage, CORDIC stages, gain stage.
// Uses c2p_pkg, c2p_prep, c2p_cordic, c2p_gain.
//
// Input beat: i_x_coord / i_y_coord (signed) on i_valid / o_ready.
// Output beat: o_radius (magnitude, input scale, rounded) and o_angle
// (unsigned binary angle, 65536 per turn, counterclockwise from +x)
// on o_valid / i_ready.
// Pipeline: one input stage, one stage per CORDIC micro-rotation, a multiply
// stage and the output register.
// Throughput: one beat per cycle while the output is not stalled; every
// stage is one register deep and the whole pipeline advances together.
// Stall: while o_valid is high and i_ready low the pipeline freezes and
// o_ready drops; nothing in flight is lost or repeated.
// Reset: synchronous, active low; clears all stage valid bits, so the
// pipeline comes up empty. The origin returns radius 0, angle 0.
`default_nettype none

module cartesian_to_polar_core
    import c2p_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output      logic                          o_ready,
    input  wire logic signed [COORD_WIDTH-1:0] i_x_coord,
    input  wire logic signed [COORD_WIDTH-1:0] i_y_coord,
    output      logic                          o_valid,
    input  wire logic                          i_ready,
    output      logic [OUT_WIDTH-1:0]          o_radius,
    output      logic [OUT_WIDTH-1:0]          o_angle
);

    logic w_en;
    logic w_prep_valid;
    t_vec w_prep_vec;
    logic w_cor_valid;
    t_vec w_cor_vec;

    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    c2p_prep u_prep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (i_valid),
        .i_x_coord (i_x_coord),
        .i_y_coord (i_y_coord),
        .o_valid   (w_prep_valid),
        .o_vec     (w_prep_vec)
    );

    c2p_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_prep_valid),
        .i_vec   (w_prep_vec),
        .o_valid (w_cor_valid),
        .o_vec   (w_cor_vec)
    );

    c2p_gain u_gain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_cor_valid),
        .i_vec    (w_cor_vec),
        .o_valid  (o_valid),
        .o_radius (o_radius),
        .o_angle  (o_angle)
    );

    // pipeline comes up empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // the half-turn fold leaves x non-negative
    a_prep_right_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_prep_valid |-> !w_prep_vec.x[DW-1])
        else $error("prep stage x negative");

    // a stalled output freezes the stages behind it
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> ($stable(w_cor_valid) && $stable(w_prep_valid)))
        else $error("pipeline moved during stall");

endmodule

`default_nettype wire

[rtl/c2p_prep.sv]
// Input stage: widens the point, folds the left half plane onto the right.
// Uses c2p_pkg.
`default_nettype none

module c2p_prep
    import c2p_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic signed [COORD_WIDTH-1:0] i_x_coord,
    input  wire logic signed [COORD_WIDTH-1:0] i_y_coord,
    output      logic                          o_valid,
    output      t_vec                          o_vec
);

    logic              r_valid;
    t_vec              r_vec;
    t_vec              n_vec;
    logic signed [DW-1:0] w_x;
    logic signed [DW-1:0] w_y;

    always_comb begin
        w_x = {{(DW-COORD_WIDTH-GUARD_BITS){i_x_coord[COORD_WIDTH-1]}},
               i_x_coord, {GUARD_BITS{1'b0}}};
        w_y = {{(DW-COORD_WIDTH-GUARD_BITS){i_y_coord[COORD_WIDTH-1]}},
               i_y_coord, {GUARD_BITS{1'b0}}};
        n_vec.zero = (i_x_coord == '0) && (i_y_coord == '0);
        if (w_x[DW-1]) begin
            n_vec.x = -w_x;
            n_vec.y = -w_y;
            n_vec.z = HALF_TURN;
        end else begin
            n_vec.x = w_x;
            n_vec.y = w_y;
            n_vec.z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec <= n_vec;
        end
    end

    assign o_valid = r_valid;
    assign o_vec   = r_vec;

endmodule

`default_nettype wire

[rtl/c2p_cordic.sv]
// Unrolled vectoring CORDIC: one registered micro-rotation per stage.
// Uses c2p_pkg.
`default_nettype none

module c2p_cordic
    import c2p_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire logic i_valid,
    input  wire t_vec i_vec,
    output      logic o_valid,
    output      t_vec o_vec
);

    logic w_valid [ITERATIONS+1];
    t_vec w_vec   [ITERATIONS+1];

    assign w_valid[0] = i_valid;
    assign w_vec[0]   = i_vec;

    for (genvar g = 0; g < ITERATIONS; g++) begin : g_stage
        logic                 r_valid;
        t_vec                 r_vec;
        t_vec                 n_vec;
        logic signed [DW-1:0] w_x;
        logic signed [DW-1:0] w_y;
        logic signed [DW-1:0] w_xs;
        logic signed [DW-1:0] w_ys;

        always_comb begin
            w_x  = w_vec[g].x;
            w_y  = w_vec[g].y;
            w_xs = w_x >>> g;
            w_ys = w_y >>> g;
            n_vec.zero = w_vec[g].zero;
            // rotate toward the x axis
            if (!w_y[DW-1]) begin
                n_vec.x = w_x + w_ys;
                n_vec.y = w_y - w_xs;
                n_vec.z = w_vec[g].z + ATAN_TABLE[g];
            end else begin
                n_vec.x = w_x - w_ys;
                n_vec.y = w_y + w_xs;
                n_vec.z = w_vec[g].z - ATAN_TABLE[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid <= 1'b0;
            end else if (i_en) begin
                r_valid <= w_valid[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_vec <= n_vec;
            end
        end

        assign w_valid[g+1] = r_valid;
        assign w_vec[g+1]   = r_vec;
    end

    assign o_valid = w_valid[ITERATIONS];
    assign o_vec   = w_vec[ITERATIONS];

endmodule

`default_nettype wire

[rtl/c2p_gain.sv]
// Gain removal and output rounding: multiply stage, then sum/round/saturate.
// Uses c2p_pkg.
`default_nettype none

module c2p_gain
    import c2p_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire t_vec                 i_vec,
    output      logic                 o_valid,
    output      logic [OUT_WIDTH-1:0] o_radius,
    output      logic [OUT_WIDTH-1:0] o_angle
);

    localparam int SW = TW - GUARD_BITS;

    // stage 1: partial products
    logic              r_valid1;
    logic [63:0]       r_plo;
    logic [HW+31:0]    r_phi;
    logic [ZW-1:0]     r_z;
    logic              r_zero;
    logic [RW-1:0]     w_mag;
    logic [31:0]       w_lo;
    logic [HW-1:0]     w_hi;

    // stage 2: output register
    logic                 r_valid2;
    logic [OUT_WIDTH-1:0] r_radius;
    logic [OUT_WIDTH-1:0] r_angle;
    logic [OUT_WIDTH-1:0] n_radius;
    logic [OUT_WIDTH-1:0] n_angle;
    logic [TW-1:0]        w_sum;
    logic [SW-1:0]        w_rad;

    always_comb begin
        // non-positive x means zero magnitude
        w_mag = i_vec.x[DW-1] ? '0 : RW'(i_vec.x[DW-2:0]);
        w_lo  = w_mag[31:0];
        w_hi  = w_mag[RW-1:32];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            r_valid2 <= 1'b0;
        end else if (i_en) begin
            r_valid1 <= i_valid;
            r_valid2 <= r_valid1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_plo  <= 64'(w_lo) * 64'(GAIN_Q32);
            r_phi  <= (HW+32)'(w_hi) * (HW+32)'(GAIN_Q32);
            r_z    <= i_vec.z;
            r_zero <= i_vec.zero;
        end
    end

    always_comb begin
        w_sum = TW'(r_plo[63:32]) + TW'(r_phi) + (TW'(1) << (GUARD_BITS - 1));
        w_rad = w_sum[TW-1:GUARD_BITS];
        if (r_zero) begin
            n_radius = '0;
            n_angle  = '0;
        end else begin
            if (w_rad > SW'({OUT_WIDTH{1'b1}})) begin
                n_radius = '1;
            end else begin
                n_radius = w_rad[OUT_WIDTH-1:0];
            end
            // round half up, carry out of the top wraps
            n_angle = r_z[ZW-1:ZW-OUT_WIDTH] + OUT_WIDTH'(r_z[ZW-OUT_WIDTH-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_radius <= n_radius;
            r_angle  <= n_angle;
        end
    end

    assign o_valid  = r_valid2;
    assign o_radius = r_radius;
    assign o_angle  = r_angle;

endmodule

`default_nettype wire

[tb/tb_cartesian_to_polar_core.sv]
// Self-checking testbench for cartesian_to_polar_core: directed points, random points
// under several idle/stall mixes, a long output hold-off and a drained pause.
// Depends on c2p_pkg (port widths) and the core itself; prediction is local.
`default_nettype none

module tb_cartesian_to_polar_core;
    import c2p_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int PIPE_DEPTH    = ITERATIONS + 3;
    localparam int STUCK_LIMIT   = 5000;
    localparam int FRAC_BITS     = 16;
    localparam int MICRO_ROTS    = 16;
    localparam logic [63:0] CORDIC_GAIN = 64'h9B74EDA8;
    localparam logic [31:0] HALF_REV    = 32'h80000000;

    // atan(2^-k), 2^32 per turn
    localparam logic [31:0] ARCTAN_LUT [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic [OUT_WIDTH-1:0] radius;
        logic [OUT_WIDTH-1:0] angle;
    } t_polar;

    logic                          i_clk     = 1'b0;
    logic                          i_rst_n   = 1'b0;
    logic                          i_valid   = 1'b0;
    logic                          o_ready;
    logic signed [COORD_WIDTH-1:0] i_x_coord = '0;
    logic signed [COORD_WIDTH-1:0] i_y_coord = '0;
    logic                          o_valid;
    logic                          i_ready   = 1'b0;
    logic [OUT_WIDTH-1:0]          o_radius;
    logic [OUT_WIDTH-1:0]          o_angle;

    t_polar pending_polar[$];
    int     mismatches     = 0;
    int     src_idle_pct   = 0;
    int     sink_stall_pct = 0;
    int     hold_req       = 0;
    int     stuck_cycles   = 0;

    cartesian_to_polar_core i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_x_coord (i_x_coord),
        .i_y_coord (i_y_coord),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_radius  (o_radius),
        .o_angle   (o_angle)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Vectoring CORDIC in 64-bit integers; >>> on longint floors.
    function automatic t_polar predict_polar(logic signed [COORD_WIDTH-1:0] xc,
                                             logic signed [COORD_WIDTH-1:0] yc);
        longint      px;
        longint      py;
        longint      sx;
        longint      sy;
        logic [31:0] acc;
        logic [63:0] mag;
        logic [63:0] scaled;
        logic [63:0] rad;
        logic [32:0] ang;
        t_polar      res;
        res = '0;
        if (xc == 0 && yc == 0)
            return res;
        px  = longint'(xc) * (64'sd1 << FRAC_BITS);
        py  = longint'(yc) * (64'sd1 << FRAC_BITS);
        acc = '0;
        // left half plane: rotate by half a turn first
        if (px < 0) begin
            px  = -px;
            py  = -py;
            acc = HALF_REV;
        end
        for (int k = 0; k < MICRO_ROTS; k++) begin
            sx = px >>> k;
            sy = py >>> k;
            if (py >= 0) begin
                px  = px + sy;
                py  = py - sx;
                acc = acc + ARCTAN_LUT[k];
            end else begin
                px  = px - sy;
                py  = py + sx;
                acc = acc - ARCTAN_LUT[k];
            end
        end
        mag    = (px > 0) ? 64'(px) : 64'd0;
        scaled = ((64'(mag[31:0]) * CORDIC_GAIN) >> 32) + (64'(mag[63:32]) * CORDIC_GAIN);
        rad    = (scaled + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (rad > 64'hFFFF)
            rad = 64'hFFFF;
        ang        = {1'b0, acc} + 33'h8000;
        res.radius = rad[15:0];
        res.angle  = ang[31:16];
        return res;
    endfunction

    // One input beat; on return the point has been accepted.
    task automatic send_point(input logic signed [COORD_WIDTH-1:0] xc,
                              input logic signed [COORD_WIDTH-1:0] yc);
        i_valid   <= 1'b1;
        i_x_coord <= xc;
        i_y_coord <= yc;
        do @(posedge i_clk); while (!o_ready);
        pending_polar.push_back(predict_polar(xc, yc));
        if ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
    endtask

    task automatic wait_drain();
        i_valid <= 1'b0;
        while (pending_polar.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic signed [COORD_WIDTH-1:0] pick_coord();
        logic signed [COORD_WIDTH-1:0] v;
        case ($urandom_range(9))
            6:       v = COORD_WIDTH'($signed($urandom_range(32)) - 16);
            7: begin
                case ($urandom_range(4))
                    0:       v = 16'sh8000;
                    1:       v = 16'sh7FFF;
                    2:       v = 16'sd0;
                    3:       v = -16'sd1;
                    default: v = 16'sd1;
                endcase
            end
            8:       v = COORD_WIDTH'($signed($urandom_range(2048)) - 1024);
            9:       v = COORD_WIDTH'((16'sd1 << $urandom_range(14)) *
                                      ($urandom_range(1) ? 1 : -1));
            default: v = COORD_WIDTH'($urandom);
        endcase
        return v;
    endfunction

    task automatic test_directed();
        logic signed [COORD_WIDTH-1:0] pts [24][2] = '{
            '{16'sd0, 16'sd0},            '{16'sd32767, 16'sd0},
            '{-16'sd32768, 16'sd0},       '{16'sd0, 16'sd32767},
            '{16'sd0, -16'sd32768},       '{16'sd32767, 16'sd32767},
            '{-16'sd32768, -16'sd32768},  '{-16'sd32768, 16'sd32767},
            '{16'sd32767, -16'sd32768},   '{16'sd1, 16'sd0},
            '{-16'sd1, 16'sd0},           '{16'sd0, 16'sd1},
            '{16'sd0, -16'sd1},           '{16'sd1, 16'sd1},
            '{-16'sd1, -16'sd1},          '{16'sd100, -16'sd1},
            '{16'sd32767, -16'sd1},       '{-16'sd1, 16'sd1},
            '{-16'sd32768, -16'sd1},      '{-16'sd32768, 16'sd1},
            '{16'sd3, 16'sd4},            '{-16'sd3, 16'sd4},
            '{16'sd12345, -16'sd6789},    '{-16'sd20000, -16'sd15000}
        };
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        foreach (pts[n])
            send_point(pts[n][0], pts[n][1]);
        wait_drain();
    endtask

    task automatic test_random(input int count, input int idle_pct, input int stall_pct);
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        repeat (count)
            send_point(pick_coord(), pick_coord());
        wait_drain();
    endtask

    // Output held off long enough for the pipe to fill and stall the input.
    task automatic test_backpressure();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_req       = 300;
        repeat (80)
            send_point(pick_coord(), pick_coord());
        wait_drain();
    endtask

    // Bursts separated by a full drain of the pipe.
    task automatic test_sender_pause();
        src_idle_pct   = 18;
        sink_stall_pct = 18;
        repeat (3) begin
            repeat (25)
                send_point(pick_coord(), pick_coord());
            wait_drain();
        end
    endtask

    // Output side: random stall, or a counted hold-off when requested.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_polar want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_polar.size() == 0) begin
                $error("unexpected result beat: radius %0d angle %0d", o_radius, o_angle);
                mismatches++;
            end else begin
                want = pending_polar.pop_front();
                if (o_radius !== want.radius) begin
                    $error("radius: expected %0d, got %0d", want.radius, o_radius);
                    mismatches++;
                end
                if (o_angle !== want.angle) begin
                    $error("angle: expected %0d, got %0d", want.angle, o_angle);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("tb_cartesian_to_polar_core NOT OK");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(260, 0, 0);
        test_random(230, 81, 0);
        test_random(230, 0, 81);
        test_random(250, 18, 18);
        test_backpressure();
        test_sender_pause();
        repeat (PIPE_DEPTH * 2) @(posedge i_clk);
        if (mismatches == 0 && pending_polar.size() == 0)
            $display("tb_cartesian_to_polar_core OK");
        else
            $display("tb_cartesian_to_polar_core NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
rtl/c2p_pkg.sv
rtl/c2p_prep.sv
rtl/c2p_cordic.sv
rtl/c2p_gain.sv
rtl/cartesian_to_polar_core.sv
tb/tb_cartesian_to_polar_core.sv
